@@ hdl/lslf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lslf_pkg;

    // Accumulator widths
    localparam int SUM_T_W  = 21;
    localparam int SUM_R_W  = 21;
    localparam int SUM_SQ_W = 37;
    localparam int SUM_RT_W = 37;
    localparam int CNT_W    = 6;
    localparam int CH_W     = 3;

    // Shared multiplier operand widths
    localparam int MA_W = 22;
    localparam int MB_W = 20;
    localparam int MP_W = MA_W + MB_W;
    localparam int MB_FULL_W = 38;
    localparam int CHUNK_W = 19;

    // Fit arithmetic widths
    localparam int ACC_W = 64;
    localparam int DEN_W = 48;

    // Divider scale codes
    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_8  = 2'd1;
    localparam logic [1:0] SH_14 = 2'd2;

    typedef struct packed {
        logic                    start;
        logic [1:0]              sh_sel;
        logic signed [ACC_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_div_req;

endpackage

`default_nettype wire

@@ hdl/lslf_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lslf_mul
    import lslf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic signed [MA_W-1:0] i_a,
    input  wire logic signed [MB_W-1:0] i_b,
    output logic signed [MP_W-1:0]      o_prod
);

    logic signed [MP_W-1:0] r_prod;

    // Register the signed product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hdl/lslf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lslf_div
    import lslf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_div_req    i_req,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;
    localparam logic [1:0] D_FIN  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ACC_W-1:0]  r_mag;
    logic [DEN_W-1:0]  r_den;
    logic [1:0]        r_sh;
    logic              r_neg;
    logic              r_sat;
    logic [DEN_W:0]    r_rem;
    logic [31:0]       r_low;
    logic [31:0]       r_q;
    logic [4:0]        r_cnt;

    logic [77:0]       m_sh;
    logic [DEN_W:0]    rem_sh;
    logic              ge;
    logic [32:0]       tot;

    // Scale the magnitude by the requested power of two
    always_comb begin
        case (r_sh)
            SH_8:    m_sh = {16'd0, r_mag[61:0]} << 8;
            SH_14:   m_sh = {16'd0, r_mag[61:0]} << 14;
            default: m_sh = {16'd0, r_mag[61:0]};
        endcase
    end

    // One restoring step
    assign rem_sh = {r_rem[DEN_W-1:0], r_low[31]};
    assign ge     = rem_sh >= {1'b0, r_den};

    // Saturate and apply the sign
    assign tot = r_sat ? 33'h1_0000_0000 : {1'b0, r_q};
    always_comb begin
        if (r_neg) begin
            o_quot = (tot >= 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - tot[31:0]);
        end else begin
            o_quot = (tot > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tot[31:0];
        end
    end
    assign o_done = (r_state == D_FIN);

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE:  if (i_req.start) n_state = D_CHK;
            D_CHK:   n_state = ({2'b00, m_sh} >= {r_den, 32'd0}) ? D_FIN : D_RUN;
            D_RUN:   if (r_cnt == 5'd0) n_state = D_FIN;
            D_FIN:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    r_neg <= i_req.num[ACC_W-1];
                    r_mag <= i_req.num[ACC_W-1] ? (64'd0 - i_req.num) : i_req.num;
                    r_den <= i_req.den;
                    r_sh  <= i_req.sh_sel;
                end
            end
            D_CHK: begin
                r_sat <= {2'b00, m_sh} >= {r_den, 32'd0};
                r_rem <= {3'd0, m_sh[77:32]};
                r_low <= m_sh[31:0];
                r_q   <= 32'd0;
                r_cnt <= 5'd31;
            end
            D_RUN: begin
                r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[30:0], ge};
                r_low <= {r_low[30:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/multichannel_least_squares_line_fit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Least-squares line fit over up to CHANNELS sensor channels against one
// reference temperature. Each calibration point is accepted in the idle state
// and then accumulated channel by channel through one shared 22x20 multiplier
// in states S_AM1, S_AM2 and S_AM3: o_ready stays low until every channel
// is accumulated, so no new point is taken before then. Points past
// MAX_POINTS are dropped from the sums. A point with last_point set starts the
// fit: per channel 12 multiply-accumulate pairs build the denominator and
// both numerators, then one iterative divider (done early when the quotient
// saturates; a division is skipped when the count is zero or the denominator
// is not positive; 4 divisions) gives means, slope and intercept. Each result
// is held until it is taken. After the last result all sums return to their
// reset values.
module multichannel_least_squares_line_fit
    import lslf_pkg::*;
#(
    parameter int CHANNELS   = 6,
    parameter int MAX_POINTS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [15:0]  i_ref_temp,
    input  wire logic [15:0]         i_reading_0,
    input  wire logic [15:0]         i_reading_1,
    input  wire logic [15:0]         i_reading_2,
    input  wire logic [15:0]         i_reading_3,
    input  wire logic [15:0]         i_reading_4,
    input  wire logic [15:0]         i_reading_5,
    input  wire logic                i_last_point,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [2:0]               o_channel,
    output logic signed [31:0]       o_slope,
    output logic signed [31:0]       o_intercept,
    output logic [15:0]              o_mean_reading,
    output logic [15:0]              o_min_reading,
    output logic [15:0]              o_max_reading,
    output logic signed [15:0]       o_mean_temp,
    output logic [5:0]               o_points_used,
    output logic                     o_fit_valid,
    output logic                     o_last
);

    localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_IW-1:0] LAST_CH = CH_IW'(CHANNELS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AM1  = 4'd1;
    localparam logic [3:0] S_AM2  = 4'd2;
    localparam logic [3:0] S_AM3  = 4'd3;
    localparam logic [3:0] S_FM   = 4'd4;
    localparam logic [3:0] S_FA   = 4'd5;
    localparam logic [3:0] S_DS   = 4'd6;
    localparam logic [3:0] S_DW   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    localparam logic [2:0] T_LAST = 3'd5;
    localparam logic [1:0] D_MX = 2'd0;
    localparam logic [1:0] D_MT = 2'd1;
    localparam logic [1:0] D_SL = 2'd2;
    localparam logic [1:0] D_IC = 2'd3;

    // Sequencer
    logic [3:0]       r_state;
    logic [CH_IW-1:0] r_ch;
    logic [2:0]       r_term;
    logic             r_chunk;
    logic [1:0]       r_dsel;

    // Run accumulators
    logic [CNT_W-1:0]           r_cnt;
    logic signed [SUM_T_W-1:0]  r_sy;
    logic [SUM_R_W-1:0]         r_sx  [CHANNELS];
    logic [SUM_SQ_W-1:0]        r_sxx [CHANNELS];
    logic signed [SUM_RT_W-1:0] r_sxy [CHANNELS];
    logic [15:0]                r_min [CHANNELS];
    logic [15:0]                r_max [CHANNELS];

    // Latched point
    logic signed [15:0] r_y;
    logic [15:0]        r_x [CHANNELS];
    logic               r_lastp;

    // Fit working registers
    logic signed [ACC_W-1:0] r_acc, r_den, r_nums, r_numi;
    logic [15:0]             r_mx, r_mt;
    logic [31:0]             r_sl;

    // Output register
    logic               r_ovalid;
    logic [2:0]         r_ochan;
    logic signed [31:0] r_oslope, r_oicpt;
    logic [15:0]        r_omx, r_omin, r_omax, r_omt;
    logic [5:0]         r_ocnt;
    logic               r_ofv, r_olast;

    logic [15:0] w_rd [6];
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] mul_p;
    logic [MB_FULL_W-1:0]   b_full;
    logic signed [ACC_W-1:0] addend;
    t_div_req div_req;
    logic        div_done;
    logic [31:0] div_q;
    logic        skip;
    logic        den_pos;
    logic        dfin;
    logic [31:0] dres;
    logic [15:0] cur_x;
    logic        in_acc, out_acc;

    assign w_rd[0] = i_reading_0;
    assign w_rd[1] = i_reading_1;
    assign w_rd[2] = i_reading_2;
    assign w_rd[3] = i_reading_3;
    assign w_rd[4] = i_reading_4;
    assign w_rd[5] = i_reading_5;

    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = r_ovalid && i_ready;
    assign cur_x   = r_x[r_ch];
    assign den_pos = !r_den[ACC_W-1] && (r_den != '0);

    // Select operands for the shared multiplier
    always_comb begin
        case (r_term)
            3'd0:    b_full = {1'b0, r_sxx[r_ch]};
            3'd1:    b_full = {17'd0, r_sx[r_ch]};
            3'd2:    b_full = {r_sxy[r_ch][SUM_RT_W-1], r_sxy[r_ch]};
            3'd3:    b_full = {{17{r_sy[SUM_T_W-1]}}, r_sy};
            3'd4:    b_full = {1'b0, r_sxx[r_ch]};
            default: b_full = {r_sxy[r_ch][SUM_RT_W-1], r_sxy[r_ch]};
        endcase
        case (r_state)
            S_AM1: begin
                mul_a = {6'd0, cur_x};
                mul_b = {4'd0, cur_x};
            end
            S_AM2: begin
                mul_a = {{6{r_y[15]}}, r_y};
                mul_b = {4'd0, cur_x};
            end
            default: begin
                case (r_term)
                    3'd0, 3'd2: mul_a = {16'd0, r_cnt};
                    3'd4:       mul_a = {r_sy[SUM_T_W-1], r_sy};
                    default:    mul_a = {1'b0, r_sx[r_ch]};
                endcase
                mul_b = r_chunk ? {b_full[MB_FULL_W-1], b_full[MB_FULL_W-1:CHUNK_W]}
                                : {1'b0, b_full[CHUNK_W-1:0]};
            end
        endcase
    end

    assign addend = {{(ACC_W-MP_W){mul_p[MP_W-1]}}, mul_p} << (r_chunk ? CHUNK_W : 0);

    lslf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_p)
    );

    // Build the divider request
    always_comb begin
        div_req.start = 1'b0;
        case (r_dsel)
            D_MX: begin
                div_req.num    = {{(ACC_W-SUM_R_W){1'b0}}, r_sx[r_ch]};
                div_req.den    = {{(DEN_W-CNT_W){1'b0}}, r_cnt};
                div_req.sh_sel = SH_0;
                skip           = (r_cnt == '0);
            end
            D_MT: begin
                div_req.num    = {{(ACC_W-SUM_T_W){r_sy[SUM_T_W-1]}}, r_sy};
                div_req.den    = {{(DEN_W-CNT_W){1'b0}}, r_cnt};
                div_req.sh_sel = SH_0;
                skip           = (r_cnt == '0);
            end
            D_SL: begin
                div_req.num    = r_nums;
                div_req.den    = r_den[DEN_W-1:0];
                div_req.sh_sel = SH_14;
                skip           = !den_pos;
            end
            default: begin
                div_req.num    = r_numi;
                div_req.den    = r_den[DEN_W-1:0];
                div_req.sh_sel = SH_8;
                skip           = !den_pos;
            end
        endcase
        if (r_state == S_DS && !skip) div_req.start = 1'b1;
    end

    lslf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign dfin = (r_state == S_DS && skip) || (r_state == S_DW && div_done);
    assign dres = (r_state == S_DW) ? div_q : 32'd0;

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= '0;
            r_term   <= '0;
            r_chunk  <= 1'b0;
            r_dsel   <= D_MX;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch    <= '0;
                        r_term  <= '0;
                        r_chunk <= 1'b0;
                        if (r_cnt < MAX_CNT) r_state <= S_AM1;
                        else if (i_last_point) r_state <= S_FM;
                    end
                end
                S_AM1: r_state <= S_AM2;
                S_AM2: r_state <= S_AM3;
                S_AM3: begin
                    if (r_ch == LAST_CH) begin
                        r_ch    <= '0;
                        r_state <= r_lastp ? S_FM : S_IDLE;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= S_AM1;
                    end
                end
                S_FM: r_state <= S_FA;
                S_FA: begin
                    r_chunk <= !r_chunk;
                    if (r_chunk && r_term == T_LAST) begin
                        r_term  <= '0;
                        r_dsel  <= D_MX;
                        r_state <= S_DS;
                    end else begin
                        if (r_chunk) r_term <= r_term + 3'd1;
                        r_state <= S_FM;
                    end
                end
                S_DS: begin
                    if (!skip) r_state <= S_DW;
                end
                default: begin
                end
            endcase
            // Advance through the divisions
            if (dfin) begin
                if (r_dsel == D_IC) begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end else begin
                    r_dsel  <= r_dsel + 2'd1;
                    r_state <= S_DS;
                end
            end
            // Release the result and move to the next channel, or back to idle after the last
            if (r_state == S_OUT && out_acc) begin
                r_ovalid <= 1'b0;
                r_chunk  <= 1'b0;
                r_term   <= '0;
                if (r_ch == LAST_CH) begin
                    r_ch    <= '0;
                    r_state <= S_IDLE;
                end else begin
                    r_ch    <= r_ch + 1'b1;
                    r_state <= S_FM;
                end
            end
        end
    end

    // Run accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == S_OUT && out_acc && r_ch == LAST_CH)) begin
            r_cnt <= '0;
            r_sy  <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_sx[k]  <= '0;
                r_sxx[k] <= '0;
                r_sxy[k] <= '0;
                r_min[k] <= 16'hFFFF;
                r_max[k] <= 16'h0000;
            end
        end else begin
            case (r_state)
                S_AM2: begin
                    r_sxx[r_ch] <= r_sxx[r_ch] + {5'd0, mul_p[31:0]};
                    r_sx[r_ch]  <= r_sx[r_ch] + {5'd0, cur_x};
                    if (cur_x < r_min[r_ch]) r_min[r_ch] <= cur_x;
                    if (cur_x > r_max[r_ch]) r_max[r_ch] <= cur_x;
                end
                S_AM3: begin
                    r_sxy[r_ch] <= r_sxy[r_ch] + {{4{mul_p[32]}}, mul_p[32:0]};
                    if (r_ch == LAST_CH) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_sy  <= r_sy + {{5{r_y[15]}}, r_y};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Point latch and fit datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_y     <= i_ref_temp;
            r_lastp <= i_last_point;
            for (int k = 0; k < CHANNELS; k++) r_x[k] <= w_rd[k];
        end
        if (r_state == S_IDLE || r_state == S_OUT) r_acc <= '0;
        if (r_state == S_FA) begin
            if (r_chunk && r_term[0]) begin
                r_acc <= '0;
                case (r_term)
                    3'd1:    r_den  <= r_acc - addend;
                    3'd3:    r_nums <= r_acc - addend;
                    default: r_numi <= r_acc - addend;
                endcase
            end else begin
                r_acc <= r_term[0] ? (r_acc - addend) : (r_acc + addend);
            end
        end
        if (dfin) begin
            case (r_dsel)
                D_MX:    r_mx <= dres[15:0];
                D_MT:    r_mt <= dres[15:0];
                D_SL:    r_sl <= dres;
                default: begin
                    r_ochan  <= {{(CH_W-CH_IW){1'b0}}, r_ch};
                    r_oslope <= r_sl;
                    r_oicpt  <= dres;
                    r_omx    <= r_mx;
                    r_omin   <= r_min[r_ch];
                    r_omax   <= r_max[r_ch];
                    r_omt    <= r_mt;
                    r_ocnt   <= r_cnt;
                    r_ofv    <= den_pos;
                    r_olast  <= (r_ch == LAST_CH);
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_channel      = r_ochan;
    assign o_slope        = r_oslope;
    assign o_intercept    = r_oicpt;
    assign o_mean_reading = r_omx;
    assign o_min_reading  = r_omin;
    assign o_max_reading  = r_omax;
    assign o_mean_temp    = r_omt;
    assign o_points_used  = r_ocnt;
    assign o_fit_valid    = r_ofv;
    assign o_last         = r_olast;

    // A pending result blocks new points
    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("point transfer possible while result pending");

    // A valid fit needs at least two points
    a_fit_needs_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fit_valid) |-> (o_points_used >= 6'd2))
        else $error("fit flagged valid with fewer than two points");

    // Min never exceeds max once a point is held
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_points_used != 6'd0) |-> (o_min_reading <= o_max_reading))
        else $error("min reading above max reading");

endmodule

`default_nettype wire
